// ===== hw/rtl/utf8d_pkg.sv =====
// Package for the UTF-8 stream decoder: event codes, result struct and
// the fixed constants of the decode. No dependencies.
package utf8d_pkg;

    // Event reported with every echoed byte
    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_CHAR    = 3'd1,
        EV_HIGH    = 3'd2,
        EV_LOW     = 3'd3,
        EV_BADCONT = 3'd4,
        EV_BADLEAD = 3'd5
    } t_event;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CODE_W   = 32;
    localparam int unsigned PAIR_W   = 21;
    localparam int unsigned LOW_W    = 10;
    localparam int unsigned REM_W    = 3;

    // Surrogate windows are checked on code[15:10]
    localparam logic [5:0] SURR_HI_TAG = 6'b110110;   // 0xD800..0xDBFF
    localparam logic [5:0] SURR_LO_TAG = 6'b110111;   // 0xDC00..0xDFFF
    localparam logic [PAIR_W-1:0] PLANE_BASE = 21'h10000;
    localparam logic [REM_W-1:0] MAX_REM = 3'd5;

    // One result request
    typedef struct packed {
        logic [BYTE_W-1:0] echo_byte;
        t_event            event_res;
        logic [CODE_W-1:0] code_value;
        logic [PAIR_W-1:0] paired_value;
    } t_result;

endpackage

// ===== hw/rtl/utf8d_core.sv =====
// Decode state registers and the one-byte step logic.
// Depends on utf8d_pkg.
module utf8d_core
    import utf8d_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [BYTE_W-1:0] i_byte,
    output t_result           o_res
);

    logic [CODE_W-1:0] r_partial, n_partial;
    logic [LOW_W-1:0]  r_saved, n_saved;
    logic [REM_W-1:0]  r_rem, n_rem;
    logic [CODE_W-1:0] shifted;
    logic [REM_W-1:0]  rem_dec;

    assign shifted = {r_partial[CODE_W-7:0], i_byte[5:0]};
    assign rem_dec = r_rem - 3'd1;

    // Next state and result for one byte
    always_comb begin
        n_partial          = r_partial;
        n_saved            = r_saved;
        n_rem              = r_rem;
        o_res.echo_byte    = i_byte;
        o_res.event_res    = EV_NONE;
        o_res.code_value   = '0;
        o_res.paired_value = '0;
        if (r_rem != '0) begin
            if (i_byte[7:6] == 2'b10) begin
                n_partial = shifted;
                n_rem     = rem_dec;
                if (rem_dec == '0) begin
                    o_res.code_value = shifted;
                    if (shifted[CODE_W-1:16] != '0) begin
                        o_res.event_res = EV_CHAR;
                    end else if (shifted[15:10] == SURR_HI_TAG) begin
                        o_res.event_res = EV_HIGH;
                    end else if (shifted[15:10] == SURR_LO_TAG) begin
                        o_res.event_res    = EV_LOW;
                        o_res.paired_value = PLANE_BASE + {1'b0, r_saved, shifted[9:0]};
                    end else begin
                        o_res.event_res = EV_CHAR;
                    end
                end
            end else begin
                // broken sequence: keep the low bits, drop the rest
                o_res.event_res = EV_BADCONT;
                n_saved         = r_partial[LOW_W-1:0];
                n_partial       = '0;
                n_rem           = '0;
            end
        end else if (i_byte[7:1] == 7'h7F) begin
            o_res.event_res = EV_BADLEAD;
        end else if (i_byte[7:6] == 2'b11) begin
            // lead byte: count of leading ones sets the continuation count
            n_saved = r_partial[LOW_W-1:0];
            priority if (!i_byte[5]) begin
                n_rem     = 3'd1;
                n_partial = {27'd0, i_byte[4:0]};
            end else if (!i_byte[4]) begin
                n_rem     = 3'd2;
                n_partial = {28'd0, i_byte[3:0]};
            end else if (!i_byte[3]) begin
                n_rem     = 3'd3;
                n_partial = {29'd0, i_byte[2:0]};
            end else if (!i_byte[2]) begin
                n_rem     = 3'd4;
                n_partial = {30'd0, i_byte[1:0]};
            end else begin
                n_rem     = 3'd5;
                n_partial = {31'd0, i_byte[0]};
            end
        end
    end

    // State registers, updated when a byte moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_saved   <= '0;
            r_rem     <= '0;
        end else if (i_en) begin
            r_partial <= n_partial;
            r_saved   <= n_saved;
            r_rem     <= n_rem;
        end
    end

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rem <= MAX_REM)
        else $error("continuation count out of range");

    a_badcont_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && o_res.event_res == EV_BADCONT) |=> (r_rem == '0 && r_partial == '0))
        else $error("bad continuation did not close the sequence");

    a_pair_plane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.event_res == EV_LOW) |-> (o_res.paired_value[20:16] != '0))
        else $error("paired value below the supplementary planes");

    a_code_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.event_res == EV_NONE || o_res.event_res == EV_BADCONT
         || o_res.event_res == EV_BADLEAD) |-> (o_res.code_value == '0))
        else $error("code value set without a completed character");

endmodule

// ===== hw/rtl/utf8_stream_decoder_unit.sv =====
// Top level of the UTF-8 stream decoder: input register, decode core and
// result register. Depends on utf8d_pkg and utf8d_core.
//
//  channel | direction | handshake          | payload
//  input   | in        | i_valid / o_stall  | i_in_byte
//  result  | out       | o_valid / i_stall  | o_echo_byte, o_event_res,
//          |           |                    | o_code_value, o_paired_value
//
// One byte per cycle sustained while the result is not stalled (i_stall low).
// The decode step sits between the input register and the result register.
// Reset (synchronous, active low) clears the decode state and both valids.
// o_stall rises only while both registers are full and the result is stalled.
module utf8_stream_decoder_unit
    import utf8d_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [BYTE_W-1:0] i_in_byte,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [BYTE_W-1:0] o_echo_byte,
    output logic [2:0]        o_event_res,
    output logic [CODE_W-1:0] o_code_value,
    output logic [PAIR_W-1:0] o_paired_value
);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    t_result           r_out;
    t_result           core_res;
    logic              move;
    logic              accept;

    // byte advances when the result register is free or being drained
    assign move    = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    utf8d_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (move),
        .i_byte  (r_in_byte),
        .o_res   (core_res)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (move) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_in_byte;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (move) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out <= core_res;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_echo_byte    = r_out.echo_byte;
    assign o_event_res    = 3'(r_out.event_res);
    assign o_code_value   = r_out.code_value;
    assign o_paired_value = r_out.paired_value;

endmodule
